/* src/afc_pkg.sv */
package afc_pkg;

	// batch capacity and derived counter width
	localparam int BATCH_CAP = 65536;
	localparam int POS_W     = $clog2(BATCH_CAP + 1);
	localparam int IDX_MAX   = 65535;

	// plane register layout
	localparam int PLANE_COUNT = 6;
	localparam int PLANE_W     = 60;
	localparam int CFG_IDX_W   = 3;
	localparam int NRM_W       = 12;
	localparam int DIST_W      = 24;
	localparam int DIST_LSB    = 36;
	localparam int DIST_SHIFT  = 10;

	// box coordinates and dot-product widths
	localparam int COORD_W = 24;
	localparam int PROD_W  = COORD_W + NRM_W;
	localparam int SUM_W   = PROD_W + 2;

	localparam int IDX_W   = 16;
	localparam int TOTAL_W = 17;

	typedef logic [PLANE_W-1:0] plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic                      batch_last;
	} box_t;

	// what one cell hands to the next
	typedef struct packed {
		logic valid;
		box_t box;
		logic pass;
	} cell_bus_t;

endpackage

/* src/afc_ifs.sv */
interface afc_box_if;
	logic                                valid;
	logic                                ready;
	logic signed [afc_pkg::COORD_W-1:0] min_x;
	logic signed [afc_pkg::COORD_W-1:0] min_y;
	logic signed [afc_pkg::COORD_W-1:0] min_z;
	logic signed [afc_pkg::COORD_W-1:0] max_x;
	logic signed [afc_pkg::COORD_W-1:0] max_y;
	logic signed [afc_pkg::COORD_W-1:0] max_z;
	logic                                batch_last;

	modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, batch_last,
		input ready);
	modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, batch_last,
		output ready);
endinterface

interface afc_res_if;
	logic                          valid;
	logic                          ready;
	logic [afc_pkg::IDX_W-1:0]     instance_index;
	logic                          visible;
	logic                          batch_end;
	logic [afc_pkg::TOTAL_W-1:0]   visible_total;

	modport source (output valid, instance_index, visible, batch_end, visible_total,
		input ready);
	modport sink (input valid, instance_index, visible, batch_end, visible_total,
		output ready);
endinterface

/* src/aabb_frustum_cull.sv */
// channel | direction | beat
// --------+-----------+-----------------------------------------------------
// box     | in        | one box: min/max corners (Q12.12) and batch_last
// res     | out       | instance_index, visible, batch_end, visible_total
// cfg     | in        | cfg_we / cfg_index / cfg_data, plane 0..5 write
//
// One box per cycle unless a held result stalls the chain. The path is six plane cells of two
// stages each (products, then sum and sign) plus the output register.
// Reset clears all planes to zero (never rejects) and both batch counters.
// A held result stalls the whole cell chain; box.ready follows that stall.
module aabb_frustum_cull (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afc_pkg::PLANE_W-1:0]   cfg_data,
	afc_box_if.sink                       box,
	afc_res_if.source                     res
);

	afc_pkg::plane_t    plane_q [afc_pkg::PLANE_COUNT];
	afc_pkg::cell_bus_t chain [afc_pkg::PLANE_COUNT+1];
	logic               adv;

	// plane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < afc_pkg::PLANE_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we && (32'(cfg_index) < 32'(afc_pkg::PLANE_COUNT))) begin
			plane_q[cfg_index] <= cfg_data;
		end
	end

	// head of chain
	assign box.ready              = adv;
	assign chain[0].valid         = box.valid;
	assign chain[0].box.min_x     = box.min_x;
	assign chain[0].box.min_y     = box.min_y;
	assign chain[0].box.min_z     = box.min_z;
	assign chain[0].box.max_x     = box.max_x;
	assign chain[0].box.max_y     = box.max_y;
	assign chain[0].box.max_z     = box.max_z;
	assign chain[0].box.batch_last = box.batch_last;
	assign chain[0].pass          = 1'b1;

	// one cell per plane
	for (genvar g = 0; g < afc_pkg::PLANE_COUNT; g++) begin : g_cell
		afc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.plane  (plane_q[g]),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// batch counting and result register
	afc_count u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (chain[afc_pkg::PLANE_COUNT]),
		.adv    (adv),
		.res    (res)
	);

endmodule

/* src/afc_cell.sv */
module afc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  afc_pkg::plane_t     plane,
	input  afc_pkg::cell_bus_t  din,
	output afc_pkg::cell_bus_t  dout
);

	logic signed [afc_pkg::NRM_W-1:0]   nx, ny, nz;
	logic signed [afc_pkg::DIST_W-1:0]  plane_d;
	logic signed [afc_pkg::COORD_W-1:0] vx, vy, vz;

	logic signed [afc_pkg::PROD_W-1:0]  px_s1, py_s1, pz_s1;
	afc_pkg::box_t                      box_s1, box_s2;
	logic                               valid_s1, valid_s2;
	logic                               pass_s1, pass_s2;

	logic signed [afc_pkg::SUM_W-1:0]   sum;

	// unpack plane
	assign nx      = plane[afc_pkg::NRM_W-1:0];
	assign ny      = plane[2*afc_pkg::NRM_W-1:afc_pkg::NRM_W];
	assign nz      = plane[3*afc_pkg::NRM_W-1:2*afc_pkg::NRM_W];
	assign plane_d = plane[afc_pkg::DIST_LSB+afc_pkg::DIST_W-1:afc_pkg::DIST_LSB];

	// positive vertex: max corner where normal is strictly positive
	assign vx = (!nx[afc_pkg::NRM_W-1] && (|nx)) ? din.box.max_x : din.box.min_x;
	assign vy = (!ny[afc_pkg::NRM_W-1] && (|ny)) ? din.box.max_y : din.box.min_y;
	assign vz = (!nz[afc_pkg::NRM_W-1] && (|nz)) ? din.box.max_z : din.box.min_z;

	// stage 1: three products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= vx * nx;
			py_s1  <= vy * ny;
			pz_s1  <= vz * nz;
			box_s1 <= din.box;
			pass_s1 <= din.pass;
		end
	end

	// stage 2: sum with scaled distance, sign decides
	assign sum = {{2{px_s1[afc_pkg::PROD_W-1]}}, px_s1}
		+ {{2{py_s1[afc_pkg::PROD_W-1]}}, py_s1}
		+ {{2{pz_s1[afc_pkg::PROD_W-1]}}, pz_s1}
		+ {{(afc_pkg::SUM_W-afc_pkg::DIST_W-afc_pkg::DIST_SHIFT){plane_d[afc_pkg::DIST_W-1]}},
			plane_d, {afc_pkg::DIST_SHIFT{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_s2  <= box_s1;
			pass_s2 <= pass_s1 && !sum[afc_pkg::SUM_W-1];
		end
	end

	assign dout.valid = valid_s2;
	assign dout.box   = box_s2;
	assign dout.pass  = pass_s2;

endmodule

/* src/afc_count.sv */
module afc_count (
	input  logic               clk,
	input  logic               arst_n,
	input  afc_pkg::cell_bus_t din,
	output logic               adv,
	afc_res_if.source          res
);

	logic [afc_pkg::POS_W-1:0] pos_q;
	logic [afc_pkg::POS_W-1:0] vis_cnt_q;
	logic [afc_pkg::POS_W-1:0] vis_cnt_next;
	logic                      in_range;
	logic                      vis;
	logic                      fire;
	logic [afc_pkg::IDX_W-1:0] idx;

	logic                        out_valid_q;
	logic [afc_pkg::IDX_W-1:0]   index_q;
	logic                        visible_q;
	logic                        batch_end_q;
	logic [afc_pkg::TOTAL_W-1:0] total_q;

	// whole chain moves when the output register is free or drained
	assign adv = !out_valid_q || res.ready;

	// capacity check and result decision
	assign in_range     = 32'(pos_q) < 32'(afc_pkg::BATCH_CAP);
	assign vis          = in_range && din.pass;
	assign vis_cnt_next = vis_cnt_q + afc_pkg::POS_W'(vis);
	assign fire         = din.valid && (vis || din.box.batch_last);
	assign idx          = (32'(pos_q) > 32'(afc_pkg::IDX_MAX)) ?
		afc_pkg::IDX_W'(afc_pkg::IDX_MAX) : afc_pkg::IDX_W'(pos_q);

	// batch counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			vis_cnt_q <= '0;
		end else if (adv && din.valid) begin
			if (din.box.batch_last) begin
				pos_q     <= '0;
				vis_cnt_q <= '0;
			end else begin
				vis_cnt_q <= vis_cnt_next;
				if (in_range) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire) begin
			index_q     <= idx;
			visible_q   <= vis;
			batch_end_q <= din.box.batch_last;
			total_q     <= afc_pkg::TOTAL_W'(vis_cnt_next);
		end
	end

	assign res.valid          = out_valid_q;
	assign res.instance_index = index_q;
	assign res.visible        = visible_q;
	assign res.batch_end      = batch_end_q;
	assign res.visible_total  = total_q;

endmodule
